// ===== hdl/fur_pkg.sv =====
// ----------------------------------------------------------------------------
// fur_pkg
// Shared types, codes and the CRC fold for the firmware update receiver.
// ----------------------------------------------------------------------------
package fur_pkg;

    localparam int MAX_WORDS   = 8192;
    localparam int IDX_W       = $clog2(MAX_WORDS);
    localparam int CNT_W       = $clog2(MAX_WORDS + 1);
    localparam int KIND_W      = 3;
    localparam int ACT_W       = 3;
    localparam int BANK_W      = 2;
    localparam int WORD_W      = 32;
    localparam int TIMEOUT_W   = 16;
    localparam int DATA_W      = 32;
    localparam int ADDR_W      = 3;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [WORD_W-1:0]    CRC_SEED      = 32'hFFFF_FFFF;
    localparam logic [WORD_W-1:0]    CRC_POLY      = 32'hDEAD_BEAF;
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd1000;

    // frame kinds
    localparam logic [KIND_W-1:0] KIND_TICK  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_START = 3'd1;
    localparam logic [KIND_W-1:0] KIND_DATA  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_END   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_CRC   = 3'd4;
    localparam logic [KIND_W-1:0] KIND_RESET = 3'd5;

    // result actions
    localparam logic [ACT_W-1:0] ACT_STORE   = 3'd0;
    localparam logic [ACT_W-1:0] ACT_PROGRAM = 3'd1;
    localparam logic [ACT_W-1:0] ACT_JUMP    = 3'd2;
    localparam logic [ACT_W-1:0] ACT_FAIL    = 3'd3;
    localparam logic [ACT_W-1:0] ACT_RESET   = 3'd4;
    localparam logic [ACT_W-1:0] ACT_HALT    = 3'd5;

    localparam logic [BANK_W-1:0] BANK_NONE = 2'd0;
    localparam logic [BANK_W-1:0] BANK_ONE  = 2'd1;
    localparam logic [BANK_W-1:0] BANK_TWO  = 2'd2;

    // register index (paddr[2])
    localparam logic REG_TIMEOUT = 1'b0;
    localparam logic REG_STORED  = 1'b1;

    typedef struct packed {
        logic [KIND_W-1:0] op;
        logic [WORD_W-1:0] value;
    } entry_t;

    typedef struct packed {
        logic [TIMEOUT_W-1:0] timeout_ms;
        logic [BANK_W-1:0]    stored_program;
        logic                 timeout_wr;
        logic [TIMEOUT_W-1:0] timeout_new;
    } cfg_t;

    // MSB-first fold of one word, 32 shifts, unrolled into an xor network
    function automatic logic [WORD_W-1:0] crc_fold(input logic [WORD_W-1:0] crc,
                                                   input logic [WORD_W-1:0] word);
        logic [WORD_W-1:0] c;
        c = crc ^ word;
        for (int k = 0; k < WORD_W; k++)
        begin
            if (c[WORD_W-1])
                c = (c << 1) ^ CRC_POLY;
            else
                c = c << 1;
        end
        return c;
    endfunction

endpackage

// ===== hdl/fur_if.sv =====
// ----------------------------------------------------------------------------
// fur_frame_if / fur_result_if
// Valid/ready channels for incoming frames and outgoing results.
// ----------------------------------------------------------------------------
interface fur_frame_if;
    import fur_pkg::*;
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [WORD_W-1:0] value;
    modport source (output valid, output kind, output value, input ready);
    modport sink   (input valid, input kind, input value, output ready);
endinterface

interface fur_result_if;
    import fur_pkg::*;
    logic              valid;
    logic              ready;
    logic [ACT_W-1:0]  action;
    logic [BANK_W-1:0] bank;
    logic [IDX_W-1:0]  word_index;
    logic [WORD_W-1:0] word_value;
    logic [CNT_W-1:0]  word_count;
    modport source (output valid, output action, output bank, output word_index,
                    output word_value, output word_count, input ready);
    modport sink   (input valid, input action, input bank, input word_index,
                    input word_value, input word_count, output ready);
endinterface

// ===== hdl/firmware_update_receiver_unit.sv =====
// ----------------------------------------------------------------------------
// firmware_update_receiver_unit
// Update session receiver: frames in, storage and verdict words out.
//
// frame:  valid/ready channel, one word per frame: kind (tick, start, data,
//         end, crc, reset) and a 32-bit value.
// result: valid/ready channel, at most one word per frame: action, bank,
//         word_index, word_value, word_count. Frames that cause no result
//         are absorbed silently.
// APB:    timeout_ms at 0x0, stored_program at 0x4; write only while idle.
// Path:   a frame passes the front register, the queue and the result
//         register in turn before its result word is valid.
// Throughput: one frame per cycle unless result stalls; the 32-shift CRC fold
//         is an unrolled xor network in the back end, so nothing iterates.
// Stall: when result is held off, the result register, the two-entry queue
//         and the front register fill in turn, then frame.ready drops.
// Reset: session idle, countdown loaded with 1000, CRC seeded all ones,
//         registers at their defaults; frames are taken at once.
// ----------------------------------------------------------------------------
module firmware_update_receiver_unit (
    input  logic                       clk,
    input  logic                       rst_n,
    fur_frame_if.sink                  frame,
    fur_result_if.source               result,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [fur_pkg::ADDR_W-1:0] paddr,
    input  logic [fur_pkg::DATA_W-1:0] pwdata,
    output logic [fur_pkg::DATA_W-1:0] prdata,
    output logic                       pready
);
    import fur_pkg::*;

    cfg_t   cfg;
    logic   push_valid;
    logic   push_ready;
    entry_t push_entry;
    logic   pop_valid;
    logic   pop_ready;
    entry_t pop_entry;

    fur_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    fur_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .frame      (frame),
        .push_valid (push_valid),
        .push_entry (push_entry),
        .push_ready (push_ready)
    );

    fur_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_entry (push_entry),
        .push_ready (push_ready),
        .pop_valid  (pop_valid),
        .pop_entry  (pop_entry),
        .pop_ready  (pop_ready)
    );

    fur_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .pop_valid (pop_valid),
        .pop_entry (pop_entry),
        .pop_ready (pop_ready),
        .result    (result)
    );

endmodule

// ===== hdl/fur_cfg.sv =====
// ----------------------------------------------------------------------------
// fur_cfg
// APB register file: start timeout and stored program bank.
// ----------------------------------------------------------------------------
module fur_cfg (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [fur_pkg::ADDR_W-1:0] paddr,
    input  logic [fur_pkg::DATA_W-1:0] pwdata,
    output logic [fur_pkg::DATA_W-1:0] prdata,
    output logic                       pready,
    output fur_pkg::cfg_t              cfg
);
    import fur_pkg::*;

    logic [TIMEOUT_W-1:0] timeout_reg;
    logic [BANK_W-1:0]    stored_reg;
    logic                 wr;
    logic                 sel;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite && pready;
    assign sel    = paddr[2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= TIMEOUT_RESET;
            stored_reg  <= BANK_NONE;
        end
        else if (wr)
        begin
            unique case (sel)
                REG_TIMEOUT: timeout_reg <= pwdata[TIMEOUT_W-1:0];
                REG_STORED:  stored_reg  <= pwdata[BANK_W-1:0];
                default:     ;
            endcase
        end
    end

    always_comb
    begin
        unique case (sel)
            REG_TIMEOUT: prdata = DATA_W'(timeout_reg);
            REG_STORED:  prdata = DATA_W'(stored_reg);
            default:     prdata = '0;
        endcase
    end

    assign cfg.timeout_ms     = timeout_reg;
    assign cfg.stored_program = stored_reg;
    assign cfg.timeout_wr     = wr && (sel == REG_TIMEOUT);
    assign cfg.timeout_new    = pwdata[TIMEOUT_W-1:0];

endmodule

// ===== hdl/fur_front.sv =====
// ----------------------------------------------------------------------------
// fur_front
// Takes frames, drops unknown kinds and registers the rest toward the queue.
// ----------------------------------------------------------------------------
module fur_front (
    input  logic            clk,
    input  logic            rst_n,
    fur_frame_if.sink       frame,
    output logic            push_valid,
    output fur_pkg::entry_t push_entry,
    input  logic            push_ready
);
    import fur_pkg::*;

    logic   valid_reg;
    logic   valid_next;
    entry_t entry_reg;
    logic   known;
    logic   take;

    assign known       = (frame.kind <= KIND_RESET);
    assign frame.ready = !valid_reg || push_ready;
    assign take        = frame.valid && frame.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (push_ready)
            valid_next = 1'b0;
        if (take)
            valid_next = known;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            entry_reg.op    <= frame.kind;
            entry_reg.value <= frame.value;
        end
    end

    assign push_valid = valid_reg;
    assign push_entry = entry_reg;

endmodule

// ===== hdl/fur_queue.sv =====
// ----------------------------------------------------------------------------
// fur_queue
// Short FIFO between front and back so each side stalls on its own.
// ----------------------------------------------------------------------------
module fur_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push_valid,
    input  fur_pkg::entry_t push_entry,
    output logic            push_ready,
    output logic            pop_valid,
    output fur_pkg::entry_t pop_entry,
    input  logic            pop_ready
);
    import fur_pkg::*;

    entry_t              mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QCNT_W-1:0]   count_reg;
    logic                push;
    logic                pop;

    assign push_ready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_entry  = mem[rd_ptr_reg];

    function automatic logic [QPTR_W-1:0] bump(input logic [QPTR_W-1:0] p);
        if (p == QPTR_W'(QUEUE_DEPTH - 1))
            return '0;
        return p + QPTR_W'(1);
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= bump(wr_ptr_reg);
            if (pop)
                rd_ptr_reg <= bump(rd_ptr_reg);
            if (push && !pop)
                count_reg <= count_reg + QCNT_W'(1);
            else if (pop && !push)
                count_reg <= count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_entry;
    end

endmodule

// ===== hdl/fur_back.sv =====
// ----------------------------------------------------------------------------
// fur_back
// Session state machine: countdown, CRC, word count, verdicts and the
// registered result stage.
// ----------------------------------------------------------------------------
module fur_back (
    input  logic            clk,
    input  logic            rst_n,
    input  fur_pkg::cfg_t   cfg,
    input  logic            pop_valid,
    input  fur_pkg::entry_t pop_entry,
    output logic            pop_ready,
    fur_result_if.source    result
);
    import fur_pkg::*;

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_RECV = 2'd1;
    localparam logic [1:0] PH_DONE = 2'd2;
    localparam logic [1:0] PH_FIN  = 2'd3;

    logic [1:0]           phase_reg,     phase_next;
    logic [TIMEOUT_W-1:0] countdown_reg, countdown_next;
    logic                 timed_out_reg, timed_out_next;
    logic [BANK_W-1:0]    target_reg,    target_next;
    logic [WORD_W-1:0]    crc_reg,       crc_next;
    logic [CNT_W-1:0]     words_reg,     words_next;
    logic                 overflow_reg,  overflow_next;
    logic                 out_valid_reg, out_valid_next;

    logic [ACT_W-1:0]     action_reg,    action_next;
    logic [BANK_W-1:0]    bank_reg,      bank_next;
    logic [IDX_W-1:0]     index_reg,     index_next;
    logic [WORD_W-1:0]    value_reg,     value_next;
    logic [CNT_W-1:0]     count_reg,     count_next;

    logic                 pop;
    logic                 emit;
    logic [TIMEOUT_W-1:0] cd_dec;
    logic [WORD_W-1:0]    crc_folded;
    logic                 stored_ok;
    logic                 target_ok;

    assign pop_ready  = !out_valid_reg || result.ready;
    assign pop        = pop_valid && pop_ready;
    assign cd_dec     = (countdown_reg != '0) ? countdown_reg - TIMEOUT_W'(1) : '0;
    assign crc_folded = crc_fold(crc_reg, pop_entry.value);
    assign stored_ok  = (cfg.stored_program == BANK_ONE) || (cfg.stored_program == BANK_TWO);
    assign target_ok  = (target_reg == BANK_ONE) || (target_reg == BANK_TWO);

    always_comb
    begin
        phase_next     = phase_reg;
        countdown_next = countdown_reg;
        timed_out_next = timed_out_reg;
        target_next    = target_reg;
        crc_next       = crc_reg;
        words_next     = words_reg;
        overflow_next  = overflow_reg;
        emit           = 1'b0;
        action_next    = ACT_STORE;
        bank_next      = BANK_NONE;
        index_next     = '0;
        value_next     = '0;
        count_next     = words_reg;

        // timeout rewritten while still counting: reload
        if (cfg.timeout_wr && phase_reg == PH_IDLE && !timed_out_reg)
            countdown_next = cfg.timeout_new;

        if (pop)
        begin
            unique case (pop_entry.op)
                KIND_RESET:
                begin
                    emit           = 1'b1;
                    action_next    = ACT_RESET;
                    phase_next     = PH_IDLE;
                    countdown_next = cfg.timeout_ms;
                    timed_out_next = 1'b0;
                    target_next    = BANK_NONE;
                    crc_next       = CRC_SEED;
                    words_next     = '0;
                    overflow_next  = 1'b0;
                end
                KIND_TICK:
                begin
                    if (phase_reg == PH_IDLE && !timed_out_reg)
                    begin
                        countdown_next = cd_dec;
                        if (cd_dec == '0)
                        begin
                            timed_out_next = 1'b1;
                            if (stored_ok)
                            begin
                                phase_next  = PH_FIN;
                                emit        = 1'b1;
                                action_next = ACT_JUMP;
                                bank_next   = cfg.stored_program;
                            end
                        end
                    end
                end
                KIND_START:
                begin
                    if (phase_reg == PH_IDLE)
                    begin
                        phase_next = PH_RECV;
                        if (pop_entry.value == WORD_W'(BANK_ONE) ||
                            pop_entry.value == WORD_W'(BANK_TWO))
                            target_next = pop_entry.value[BANK_W-1:0];
                        else
                            target_next = BANK_NONE;
                    end
                end
                KIND_DATA:
                begin
                    if (phase_reg == PH_RECV)
                    begin
                        if (words_reg >= CNT_W'(MAX_WORDS))
                            overflow_next = 1'b1;
                        else
                        begin
                            crc_next    = crc_folded;
                            words_next  = words_reg + CNT_W'(1);
                            emit        = 1'b1;
                            action_next = ACT_STORE;
                            index_next  = words_reg[IDX_W-1:0];
                            value_next  = pop_entry.value;
                            count_next  = words_reg + CNT_W'(1);
                        end
                    end
                end
                KIND_END:
                begin
                    if (phase_reg == PH_RECV)
                        phase_next = PH_DONE;
                end
                KIND_CRC:
                begin
                    if (phase_reg == PH_RECV || phase_reg == PH_DONE)
                    begin
                        emit       = 1'b1;
                        value_next = crc_reg;
                        if (overflow_reg || crc_reg != pop_entry.value)
                        begin
                            action_next    = ACT_FAIL;
                            phase_next     = PH_IDLE;
                            countdown_next = cfg.timeout_ms;
                            timed_out_next = 1'b0;
                            target_next    = BANK_NONE;
                            crc_next       = CRC_SEED;
                            words_next     = '0;
                            overflow_next  = 1'b0;
                        end
                        else
                        begin
                            phase_next = PH_FIN;
                            if (target_ok)
                            begin
                                action_next = ACT_PROGRAM;
                                bank_next   = target_reg;
                                words_next  = '0;
                            end
                            else
                                action_next = ACT_HALT;
                        end
                    end
                end
                default: ;
            endcase
        end

        out_valid_next = out_valid_reg;
        if (result.ready)
            out_valid_next = 1'b0;
        if (emit)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            countdown_reg <= TIMEOUT_RESET;
            timed_out_reg <= 1'b0;
            target_reg    <= BANK_NONE;
            crc_reg       <= CRC_SEED;
            words_reg     <= '0;
            overflow_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            countdown_reg <= countdown_next;
            timed_out_reg <= timed_out_next;
            target_reg    <= target_next;
            crc_reg       <= crc_next;
            words_reg     <= words_next;
            overflow_reg  <= overflow_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            action_reg <= action_next;
            bank_reg   <= bank_next;
            index_reg  <= index_next;
            value_reg  <= value_next;
            count_reg  <= count_next;
        end
    end

    assign result.valid      = out_valid_reg;
    assign result.action     = action_reg;
    assign result.bank       = bank_reg;
    assign result.word_index = index_reg;
    assign result.word_value = value_reg;
    assign result.word_count = count_reg;

endmodule

// ===== verif/tb_firmware_update_receiver_unit.sv =====
// ----------------------------------------------------------------------------
// tb_firmware_update_receiver_unit
// Self-checking bench for the firmware update receiver: a frame driver and a
// result monitor run off queues, a behavioral session model predicts every
// result word, and APB writes switch timeout and stored program between runs.
// ----------------------------------------------------------------------------
module tb_firmware_update_receiver_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import fur_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 8;
    localparam int LONG_HOLD      = 60;

    typedef enum logic [1:0] {PH_IDLE, PH_RECEIVING, PH_DONE, PH_FINISHED} session_phase_t;

    typedef struct packed {
        logic [ACT_W-1:0]  action;
        logic [BANK_W-1:0] bank;
        logic [IDX_W-1:0]  word_index;
        logic [WORD_W-1:0] word_value;
        logic [CNT_W-1:0]  word_count;
    } result_word_t;

    logic clk = 1'b0;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic pready;

    fur_frame_if  frame_bus ();
    fur_result_if result_bus ();

    firmware_update_receiver_unit dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .frame   (frame_bus),
        .result  (result_bus),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // stimulus and expectations
    entry_t       pending_frames[$];
    result_word_t expected_words[$];

    int src_idle_pct;
    int snk_idle_pct;
    logic long_hold_req;
    int errors;
    int frames_taken;
    int results_seen;
    int act_seen[8];

    // session model state
    logic [TIMEOUT_W-1:0] cfg_timeout;
    logic [BANK_W-1:0]    cfg_stored;
    session_phase_t       ses_phase;
    logic [TIMEOUT_W-1:0] countdown;
    logic                 expired;
    logic [BANK_W-1:0]    target_bank;
    logic [WORD_W-1:0]    session_crc;
    logic [CNT_W-1:0]     session_words;
    logic                 overflowed;

    function automatic logic [WORD_W-1:0] crc_fold32(input logic [WORD_W-1:0] crc,
                                                      input logic [WORD_W-1:0] word);
        logic [WORD_W-1:0] c;
        c = crc ^ word;
        for (int k = 0; k < WORD_W; k++)
        begin
            c = c[WORD_W-1] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

    task automatic clear_session();
        ses_phase     = PH_IDLE;
        countdown     = cfg_timeout;
        expired       = 1'b0;
        target_bank   = BANK_NONE;
        session_crc   = CRC_SEED;
        session_words = '0;
        overflowed    = 1'b0;
    endtask

    task automatic push_result(input logic [ACT_W-1:0] act, input logic [BANK_W-1:0] bank,
                               input logic [IDX_W-1:0] idx, input logic [WORD_W-1:0] val,
                               input logic [CNT_W-1:0] cnt);
        result_word_t r;
        r.action     = act;
        r.bank       = bank;
        r.word_index = idx;
        r.word_value = val;
        r.word_count = cnt;
        expected_words.push_back(r);
    endtask

    // advance the session model by one accepted frame
    task automatic session_step(input logic [KIND_W-1:0] kind, input logic [WORD_W-1:0] val);
        logic [CNT_W-1:0] cnt;
        cnt = session_words;
        case (kind)
            KIND_RESET:
            begin
                push_result(ACT_RESET, BANK_NONE, '0, '0, cnt);
                clear_session();
            end
            KIND_TICK:
            begin
                if (ses_phase == PH_IDLE && !expired)
                begin
                    if (countdown != 0)
                        countdown = countdown - 1'b1;
                    if (countdown == 0)
                    begin
                        expired = 1'b1;
                        if (cfg_stored == BANK_ONE || cfg_stored == BANK_TWO)
                        begin
                            ses_phase = PH_FINISHED;
                            push_result(ACT_JUMP, cfg_stored, '0, '0, cnt);
                        end
                    end
                end
            end
            KIND_START:
            begin
                if (ses_phase == PH_IDLE)
                begin
                    if (val == WORD_W'(BANK_ONE) || val == WORD_W'(BANK_TWO))
                        target_bank = val[BANK_W-1:0];
                    else
                        target_bank = BANK_NONE;
                    ses_phase = PH_RECEIVING;
                end
            end
            KIND_DATA:
            begin
                if (ses_phase == PH_RECEIVING)
                begin
                    if (session_words >= MAX_WORDS)
                        overflowed = 1'b1;
                    else
                    begin
                        session_crc   = crc_fold32(session_crc, val);
                        session_words = session_words + 1'b1;
                        push_result(ACT_STORE, BANK_NONE, IDX_W'(cnt), val, session_words);
                    end
                end
            end
            KIND_END:
            begin
                if (ses_phase == PH_RECEIVING)
                    ses_phase = PH_DONE;
            end
            KIND_CRC:
            begin
                if (ses_phase == PH_RECEIVING || ses_phase == PH_DONE)
                begin
                    if (overflowed || session_crc != val)
                    begin
                        push_result(ACT_FAIL, BANK_NONE, '0, session_crc, cnt);
                        clear_session();
                    end
                    else
                    begin
                        ses_phase = PH_FINISHED;
                        if (target_bank == BANK_ONE || target_bank == BANK_TWO)
                        begin
                            session_words = '0;
                            push_result(ACT_PROGRAM, target_bank, '0, session_crc, cnt);
                        end
                        else
                            push_result(ACT_HALT, BANK_NONE, '0, session_crc, cnt);
                    end
                end
            end
            default:
            begin
            end
        endcase
    endtask

    // frame driver
    always @(posedge clk or negedge rst_n)
    begin
        entry_t item;
        if (!rst_n)
        begin
            frame_bus.valid <= 1'b0;
            frame_bus.kind  <= '0;
            frame_bus.value <= '0;
        end
        else
        begin
            if (frame_bus.valid && frame_bus.ready)
            begin
                frames_taken++;
                session_step(frame_bus.kind, frame_bus.value);
            end
            if (!frame_bus.valid || frame_bus.ready)
            begin
                if (pending_frames.size() != 0 && $urandom_range(99) >= src_idle_pct)
                begin
                    item = pending_frames.pop_front();
                    frame_bus.valid <= 1'b1;
                    frame_bus.kind  <= item.op;
                    frame_bus.value <= item.value;
                end
                else
                    frame_bus.valid <= 1'b0;
            end
        end
    end

    task automatic check_field(input string what, input logic [WORD_W-1:0] want,
                               input logic [WORD_W-1:0] got);
        if (want !== got)
        begin
            errors++;
            $display("%0t: %s mismatch: expected 0x%0h, got 0x%0h", $time, what, want, got);
        end
    endtask

    // result monitor with its own long hold-off counter
    int  hold_left;
    logic hold_done;

    always @(posedge clk or negedge rst_n)
    begin
        result_word_t want;
        if (!rst_n)
        begin
            result_bus.ready <= 1'b0;
            hold_left        <= 0;
            hold_done        <= 1'b0;
        end
        else
        begin
            if (result_bus.valid && result_bus.ready)
            begin
                results_seen++;
                act_seen[int'(result_bus.action)]++;
                if (expected_words.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected word: action %0d bank %0d index %0d",
                             $time, result_bus.action, result_bus.bank,
                             result_bus.word_index);
                    $display("  value 0x%0h count %0d",
                             result_bus.word_value, result_bus.word_count);
                end
                else
                begin
                    want = expected_words.pop_front();
                    check_field("action", WORD_W'(want.action),
                                WORD_W'(result_bus.action));
                    check_field("bank", WORD_W'(want.bank), WORD_W'(result_bus.bank));
                    check_field("word_index", WORD_W'(want.word_index),
                                WORD_W'(result_bus.word_index));
                    check_field("word_value", want.word_value, result_bus.word_value);
                    check_field("word_count", WORD_W'(want.word_count),
                                WORD_W'(result_bus.word_count));
                end
            end
            if (hold_left != 0)
            begin
                hold_left        <= hold_left - 1;
                result_bus.ready <= 1'b0;
            end
            else if (long_hold_req && !hold_done)
            begin
                hold_left        <= LONG_HOLD;
                hold_done        <= 1'b1;
                result_bus.ready <= 1'b0;
            end
            else
                result_bus.ready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    // watchdog: cycles with no handshake on either channel
    int quiet_cycles;

    always @(posedge clk)
    begin
        if (!rst_n || (frame_bus.valid && frame_bus.ready) ||
            (result_bus.valid && result_bus.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no handshake for %0d cycles, %0d words still expected",
                     $time, quiet_cycles, expected_words.size());
            $display("*** FAILED ***");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    task automatic push_frame(input logic [KIND_W-1:0] kind, input logic [WORD_W-1:0] val);
        entry_t e;
        e.op    = kind;
        e.value = val;
        pending_frames.push_back(e);
    endtask

    task automatic write_reg(input logic idx, input logic [DATA_W-1:0] data);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_TIMEOUT)
        begin
            cfg_timeout = data[TIMEOUT_W-1:0];
            if (ses_phase == PH_IDLE && !expired)
                countdown = cfg_timeout;
        end
        else
            cfg_stored = data[BANK_W-1:0];
    endtask

    // upper data bits are don't-care, so fill them with noise
    task automatic configure(input logic [TIMEOUT_W-1:0] tmo, input logic [BANK_W-1:0] stored);
        write_reg(REG_TIMEOUT, {16'($urandom), tmo});
        write_reg(REG_STORED, {30'($urandom), stored});
    endtask

    // wait until every frame is taken and every word checked, then let the
    // pipeline empty of frames that produce nothing
    task automatic drain();
        do
            @(negedge clk);
        while (pending_frames.size() != 0 || frame_bus.valid || expected_words.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic queue_directed();
        logic [WORD_W-1:0] crc;
        // zero timeout: first idle tick expires and jumps to bank one
        configure(16'd0, BANK_ONE);
        push_frame(KIND_TICK, 32'h0);
        push_frame(KIND_DATA, 32'h1234);
        push_frame(KIND_RESET, 32'hFFFF_FFFF);
        drain();

        // expiry with nothing stored, then ignored frames in idle
        configure(16'd2, BANK_NONE);
        push_frame(KIND_TICK, 32'h0);
        push_frame(KIND_TICK, 32'h0);
        push_frame(KIND_TICK, 32'h0);
        push_frame(KIND_END, 32'h0);
        push_frame(KIND_CRC, CRC_SEED);
        push_frame(KIND_DATA, 32'h7);
        push_frame(KIND_START, 32'h2);
        push_frame(KIND_START, 32'h1);
        push_frame(KIND_TICK, 32'h0);
        push_frame(KIND_DATA, 32'h0);
        push_frame(KIND_DATA, 32'hFFFF_FFFF);
        push_frame(3'd6, $urandom);
        push_frame(3'd7, $urandom);
        push_frame(KIND_END, 32'h0);
        push_frame(KIND_DATA, 32'hA5A5_A5A5);
        crc = crc_fold32(crc_fold32(CRC_SEED, 32'h0), 32'hFFFF_FFFF);
        push_frame(KIND_CRC, crc);
        push_frame(KIND_RESET, 32'h0);
        // bad bank, crc straight from receiving -> halt
        push_frame(KIND_START, 32'hFFFF_FFFF);
        push_frame(KIND_DATA, 32'h8000_0000);
        push_frame(KIND_CRC, crc_fold32(CRC_SEED, 32'h8000_0000));
        push_frame(KIND_RESET, 32'h0);
        // corrupted crc
        push_frame(KIND_START, 32'h1);
        push_frame(KIND_DATA, 32'h5A5A_5A5A);
        push_frame(KIND_CRC, ~crc_fold32(CRC_SEED, 32'h5A5A_5A5A));
        drain();
    endtask

    // mostly well-formed sessions with random content, some noise
    task automatic queue_sessions(input int target);
        int made;
        int first;
        int sel;
        logic [WORD_W-1:0] crc;
        logic [WORD_W-1:0] w;
        made = 0;
        while (made < target)
        begin
            if ($urandom_range(99) < 12)
            begin
                repeat ($urandom_range(1, 4))
                    push_frame(KIND_W'($urandom_range(7)), $urandom);
            end
            else
            begin
                first = pending_frames.size();
                if ($urandom_range(9) != 0)
                    push_frame(KIND_RESET, $urandom);
                repeat ($urandom_range(2))
                    push_frame(KIND_TICK, $urandom);
                sel = $urandom_range(9);
                if (sel == 0)
                    w = $urandom;
                else if (sel < 5)
                    w = WORD_W'(BANK_ONE);
                else
                    w = WORD_W'(BANK_TWO);
                push_frame(KIND_START, w);
                crc = CRC_SEED;
                repeat ($urandom_range(12))
                begin
                    if ($urandom_range(9) == 0)
                        push_frame($urandom_range(1) ? KIND_TICK : KIND_START, $urandom);
                    if ($urandom_range(7) == 0)
                        w = $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0;
                    else
                        w = $urandom;
                    crc = crc_fold32(crc, w);
                    push_frame(KIND_DATA, w);
                end
                if ($urandom_range(1))
                    push_frame(KIND_END, $urandom);
                if ($urandom_range(4) == 0)
                    crc = crc ^ (32'h1 << $urandom_range(31));
                push_frame(KIND_CRC, crc);
                made += pending_frames.size() - first;
            end
        end
    endtask

    initial
    begin
        rst_n            = 1'b0;
        psel             = 1'b0;
        penable          = 1'b0;
        pwrite           = 1'b0;
        paddr            = '0;
        pwdata           = '0;
        long_hold_req    = 1'b0;
        errors           = 0;
        frames_taken     = 0;
        results_seen     = 0;
        cfg_timeout      = TIMEOUT_RESET;
        cfg_stored       = BANK_NONE;
        clear_session();
        src_idle_pct = 14;
        snk_idle_pct = 78;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        queue_directed();

        configure(16'd3, BANK_ONE);
        queue_sessions(250);
        long_hold_req = 1'b1;
        drain();

        src_idle_pct = 78;
        snk_idle_pct = 14;
        configure(16'hFFFF, 2'd3);
        queue_sessions(250);
        drain();

        src_idle_pct = 0;
        snk_idle_pct = 0;
        configure(16'd1, BANK_TWO);
        queue_sessions(250);
        drain();

        $display("Covered %0d frames and %0d result words: %0d stores, %0d program, %0d jump,",
                 frames_taken, results_seen, act_seen[ACT_STORE], act_seen[ACT_PROGRAM],
                 act_seen[ACT_JUMP]);
        $display("  %0d crc fail, %0d reset, %0d halt; timeouts 0..65535, one long result stall",
                 act_seen[ACT_FAIL], act_seen[ACT_RESET], act_seen[ACT_HALT]);
        if (errors == 0 && expected_words.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/fur_pkg.sv
hdl/fur_if.sv
hdl/fur_cfg.sv
hdl/fur_front.sv
hdl/fur_queue.sv
hdl/fur_back.sv
hdl/firmware_update_receiver_unit.sv
verif/tb_firmware_update_receiver_unit.sv
